// ===== hdl/gml_pkg.sv =====
// ----------------------------------------------------------------------------
// Gate motor limit controller package
// Shared types, codes, reset values and the limit switch debounce function.
// ----------------------------------------------------------------------------
package gml_pkg;

	// Sizing
	localparam int MOTOR_COUNT_DEF = 2;
	localparam int CMD_Q_DEPTH     = 4;
	localparam int RES_Q_DEPTH     = 2;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 8;

	// Item commands / report kinds
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	// Motor status
	localparam logic [1:0] ST_STOPPED  = 2'd0;
	localparam logic [1:0] ST_STOPPING = 2'd1;
	localparam logic [1:0] ST_FORWARD  = 2'd2;
	localparam logic [1:0] ST_BACKWARD = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_OK          = 2'd0;
	localparam logic [1:0] ERR_NOT_STOPPED = 2'd1;
	localparam logic [1:0] ERR_UPPER       = 2'd2;
	localparam logic [1:0] ERR_LOWER       = 2'd3;

	// Drive commands
	localparam logic [1:0] DRV_NONE = 2'd0;
	localparam logic [1:0] DRV_FWD  = 2'd1;
	localparam logic [1:0] DRV_BWD  = 2'd2;
	localparam logic [1:0] DRV_STOP = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_READ_WINDOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_DELAY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_DUTY   = 3'd3;

	// Register reset values
	localparam logic [3:0] READ_WINDOW_RST  = 4'd10;
	localparam logic [3:0] STABLE_COUNT_RST = 4'd8;
	localparam logic [7:0] STOP_DELAY_RST   = 8'd200;

	typedef struct packed {
		logic [3:0] read_window;
		logic [3:0] stable_count;
		logic [7:0] stop_delay;
	} cfg_t;

	// Classified item as it travels from front end to back end
	typedef struct packed {
		logic [1:0] cmd;
		logic       motor;
		logic       motor_ok;
		logic       direction;
		logic [7:0] run_timeout;
		logic       high_pin;
		logic       low_pin;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0] report_kind;
		logic       report_motor;
		logic       report_direction;
		logic [1:0] error_code;
		logic [1:0] motor_state;
		logic       upper_reached;
		logic       lower_reached;
		logic [1:0] drive_cmd;
		logic [7:0] drive_timeout;
	} result_t;

	typedef struct packed {
		logic       reached;
		logic [3:0] samples;
		logic [3:0] idles;
		logic [3:0] reaches;
	} sw_t;

	typedef struct packed {
		sw_t  sw;
		logic newly;
	} deb_t;

	// One sample into a switch's window; newly flags a fresh reach
	function automatic deb_t debounce(sw_t s, logic level, logic [3:0] window,
	                                  logic [3:0] stable);
		deb_t r;
		r.sw         = s;
		r.newly      = 1'b0;
		r.sw.samples = s.samples + 4'd1;
		if (level) begin
			r.sw.reaches = s.reaches + 4'd1;
		end else begin
			r.sw.idles = s.idles + 4'd1;
		end
		if (r.sw.samples >= window) begin
			if (r.sw.idles >= stable) begin
				r.sw.reached = 1'b0;
			end else if (r.sw.reaches >= stable) begin
				r.newly      = ~s.reached;
				r.sw.reached = 1'b1;
			end
			r.sw.samples = 4'd0;
			r.sw.idles   = 4'd0;
			r.sw.reaches = 4'd0;
		end
		return r;
	endfunction

endpackage

// ===== hdl/gml_fifo.sv =====
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based first-word-fall-through queue with full and empty flags.
// ----------------------------------------------------------------------------
module gml_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr_en || rd_en)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !rd_en)
		else $error("queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on a write");

endmodule

// ===== hdl/gml_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Accepts items, checks the motor number and hands classified items to the
// command queue.
// ----------------------------------------------------------------------------
module gml_front #(
	parameter int MOTOR_COUNT = gml_pkg::MOTOR_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         cmd,
	input  logic               motor,
	input  logic               direction,
	input  logic [7:0]         run_timeout,
	input  logic               high_pin,
	input  logic               low_pin,
	input  logic               q_full,
	output logic               q_push,
	output gml_pkg::cmd_item_t q_item
);

	logic               valid_s1;
	gml_pkg::cmd_item_t item_s1;
	logic               accept;

	assign full   = valid_s1 & q_full;
	assign accept = push & ~full;
	assign q_push = valid_s1 & ~q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd         <= cmd;
			item_s1.motor       <= motor;
			item_s1.motor_ok    <= (int'(motor) < MOTOR_COUNT);
			item_s1.direction   <= direction;
			item_s1.run_timeout <= run_timeout;
			item_s1.high_pin    <= high_pin;
			item_s1.low_pin     <= low_pin;
		end
	end

endmodule

// ===== hdl/gml_back.sv =====
// ----------------------------------------------------------------------------
// Back end
// Carries out ticks and commands against per-motor state as a
// read-modify-write and pushes one result per item.
// ----------------------------------------------------------------------------
module gml_back #(
	parameter int MOTOR_COUNT = gml_pkg::MOTOR_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gml_pkg::cfg_t      cfg,
	input  logic               q_empty,
	input  gml_pkg::cmd_item_t q_item,
	output logic               q_pop,
	input  logic               res_full,
	output logic               res_push,
	output gml_pkg::result_t   res
);

	localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	logic [1:0]   status_q [MOTOR_COUNT];
	logic [7:0]   countdown_q [MOTOR_COUNT];
	gml_pkg::sw_t upper_q [MOTOR_COUNT];
	gml_pkg::sw_t lower_q [MOTOR_COUNT];

	logic [IDX_W-1:0] idx;
	logic             upd;
	logic [1:0]       nxt_st;
	logic [7:0]       nxt_cd;
	gml_pkg::sw_t     nxt_up;
	gml_pkg::sw_t     nxt_lo;
	gml_pkg::deb_t    deb_up;
	gml_pkg::deb_t    deb_lo;
	logic [1:0]       err;
	logic [1:0]       drive;
	logic [7:0]       dtmo;

	assign q_pop    = ~q_empty & ~res_full;
	assign res_push = q_pop;
	assign idx      = IDX_W'(q_item.motor);
	assign upd      = q_pop & q_item.motor_ok;

	always_comb begin
		nxt_st = status_q[idx];
		nxt_cd = countdown_q[idx];
		nxt_up = upper_q[idx];
		nxt_lo = lower_q[idx];
		err    = gml_pkg::ERR_OK;
		drive  = gml_pkg::DRV_NONE;
		dtmo   = 8'd0;
		deb_up = gml_pkg::debounce(upper_q[idx], q_item.high_pin,
		                           cfg.read_window, cfg.stable_count);
		deb_lo = gml_pkg::debounce(lower_q[idx], q_item.low_pin,
		                           cfg.read_window, cfg.stable_count);
		if (q_item.motor_ok) begin
			case (q_item.cmd)
				gml_pkg::CMD_TICK: begin
					if (nxt_st == gml_pkg::ST_STOPPING) begin
						if (nxt_cd <= 8'd1) begin
							nxt_cd = 8'd0;
							nxt_st = gml_pkg::ST_STOPPED;
						end else begin
							nxt_cd = nxt_cd - 8'd1;
						end
					end
					nxt_up = deb_up.sw;
					nxt_lo = deb_lo.sw;
					// upper switch first, then lower
					if (deb_up.newly && nxt_st == gml_pkg::ST_FORWARD) begin
						nxt_st = gml_pkg::ST_STOPPING;
						nxt_cd = cfg.stop_delay;
						drive  = gml_pkg::DRV_STOP;
					end
					if (deb_lo.newly && nxt_st == gml_pkg::ST_BACKWARD) begin
						nxt_st = gml_pkg::ST_STOPPING;
						nxt_cd = cfg.stop_delay;
						drive  = gml_pkg::DRV_STOP;
					end
				end
				gml_pkg::CMD_START: begin
					if (nxt_st != gml_pkg::ST_STOPPED) begin
						err = gml_pkg::ERR_NOT_STOPPED;
					end else if (!q_item.direction) begin
						if (nxt_up.reached) begin
							err = gml_pkg::ERR_UPPER;
						end else begin
							nxt_st = gml_pkg::ST_FORWARD;
							drive  = gml_pkg::DRV_FWD;
							dtmo   = q_item.run_timeout;
						end
					end else begin
						if (nxt_lo.reached) begin
							err = gml_pkg::ERR_LOWER;
						end else begin
							nxt_st = gml_pkg::ST_BACKWARD;
							drive  = gml_pkg::DRV_BWD;
							dtmo   = q_item.run_timeout;
						end
					end
				end
				gml_pkg::CMD_STOP: begin
					if (nxt_st == gml_pkg::ST_FORWARD || nxt_st == gml_pkg::ST_BACKWARD) begin
						nxt_st = gml_pkg::ST_STOPPING;
						nxt_cd = cfg.stop_delay;
						drive  = gml_pkg::DRV_STOP;
					end
				end
				default: begin
				end
			endcase
		end else if (q_item.cmd == gml_pkg::CMD_START) begin
			err = gml_pkg::ERR_NOT_STOPPED;
		end
	end

	always_comb begin
		res.report_kind      = q_item.cmd;
		res.report_motor     = q_item.motor;
		res.report_direction = (q_item.cmd == gml_pkg::CMD_START) ? q_item.direction : 1'b0;
		res.error_code       = err;
		res.motor_state      = q_item.motor_ok ? nxt_st : gml_pkg::ST_STOPPED;
		res.upper_reached    = q_item.motor_ok & nxt_up.reached;
		res.lower_reached    = q_item.motor_ok & nxt_lo.reached;
		res.drive_cmd        = drive;
		res.drive_timeout    = dtmo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				status_q[i]    <= gml_pkg::ST_STOPPED;
				countdown_q[i] <= 8'd0;
				upper_q[i]     <= '0;
				lower_q[i]     <= '0;
			end
		end else if (upd) begin
			status_q[idx]    <= nxt_st;
			countdown_q[idx] <= nxt_cd;
			upper_q[idx]     <= nxt_up;
			lower_q[idx]     <= nxt_lo;
		end
	end

	for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_chk
		a_countdown_idle: assert property (@(posedge clk) disable iff (!arst_n)
			status_q[g] != gml_pkg::ST_STOPPING |-> countdown_q[g] == 8'd0)
			else $error("stop countdown running outside stopping");
	end

	a_stop_drive: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.drive_cmd == gml_pkg::DRV_STOP
		|-> res.motor_state == gml_pkg::ST_STOPPING)
		else $error("stop drive without stopping status");
	a_run_drive: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && (res.drive_cmd == gml_pkg::DRV_FWD || res.drive_cmd == gml_pkg::DRV_BWD)
		|-> res.report_kind == gml_pkg::CMD_START && res.error_code == gml_pkg::ERR_OK)
		else $error("run drive outside an accepted start");
	a_bad_motor: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !q_item.motor_ok
		|-> res.motor_state == gml_pkg::ST_STOPPED && res.drive_cmd == gml_pkg::DRV_NONE)
		else $error("unknown motor produced a state or drive");

endmodule

// ===== hdl/gate_motor_limit_controller.sv =====
// ----------------------------------------------------------------------------
// Gate motor limit controller
// Debounces limit switches and runs start, stop and query commands for a
// set of gate motors.
// ----------------------------------------------------------------------------
// Path: push -> front stage -> command queue -> back end -> result queue.
// Throughput: one item per cycle while the result queue has room, set by
// the per-motor read-modify-write of status, countdown and switch counters.
// Reset: queues empty, all motors stopped, switches idle, counts zero,
// registers at read_window 10, stable_count 8, stop_delay 200.
module gate_motor_limit_controller #(
	parameter int MOTOR_COUNT = gml_pkg::MOTOR_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [1:0]                     cmd,
	input  logic                           motor,
	input  logic                           direction,
	input  logic [7:0]                     run_timeout,
	input  logic                           high_pin,
	input  logic                           low_pin,
	output logic                           empty,
	input  logic                           pop,
	output logic [1:0]                     report_kind,
	output logic                           report_motor,
	output logic                           report_direction,
	output logic [1:0]                     error_code,
	output logic [1:0]                     motor_state,
	output logic                           upper_reached,
	output logic                           lower_reached,
	output logic [1:0]                     drive_cmd,
	output logic [7:0]                     drive_timeout,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gml_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gml_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ITEM_W = $bits(gml_pkg::cmd_item_t);
	localparam int RES_W  = $bits(gml_pkg::result_t);

	gml_pkg::cfg_t      cfg_q;
	logic               cq_push;
	logic               cq_full;
	logic               cq_pop;
	logic               cq_empty;
	gml_pkg::cmd_item_t cq_wr_item;
	gml_pkg::cmd_item_t cq_rd_item;
	logic               rq_push;
	logic               rq_full;
	gml_pkg::result_t   rq_wr;
	gml_pkg::result_t   rq_rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_window  <= gml_pkg::READ_WINDOW_RST;
			cfg_q.stable_count <= gml_pkg::STABLE_COUNT_RST;
			cfg_q.stop_delay   <= gml_pkg::STOP_DELAY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				gml_pkg::CFG_READ_WINDOW:  cfg_q.read_window  <= cfg_data[3:0];
				gml_pkg::CFG_STABLE_COUNT: cfg_q.stable_count <= cfg_data[3:0];
				gml_pkg::CFG_STOP_DELAY:   cfg_q.stop_delay   <= cfg_data;
				// duty feeds no result field; take the beat and drop it
				gml_pkg::CFG_DRIVE_DUTY:   cfg_q <= cfg_q;
				default:                   cfg_q <= cfg_q;
			endcase
		end
	end

	gml_front #(
		.MOTOR_COUNT(MOTOR_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.motor      (motor),
		.direction  (direction),
		.run_timeout(run_timeout),
		.high_pin   (high_pin),
		.low_pin    (low_pin),
		.q_full     (cq_full),
		.q_push     (cq_push),
		.q_item     (cq_wr_item)
	);

	gml_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(gml_pkg::CMD_Q_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cq_push),
		.wr_data(cq_wr_item),
		.full   (cq_full),
		.rd_en  (cq_pop),
		.rd_data(cq_rd_item),
		.empty  (cq_empty)
	);

	gml_back #(
		.MOTOR_COUNT(MOTOR_COUNT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (cq_empty),
		.q_item  (cq_rd_item),
		.q_pop   (cq_pop),
		.res_full(rq_full),
		.res_push(rq_push),
		.res     (rq_wr)
	);

	gml_fifo #(
		.WIDTH(RES_W),
		.DEPTH(gml_pkg::RES_Q_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rq_push),
		.wr_data(rq_wr),
		.full   (rq_full),
		.rd_en  (pop & ~empty),
		.rd_data(rq_rd),
		.empty  (empty)
	);

	assign report_kind      = rq_rd.report_kind;
	assign report_motor     = rq_rd.report_motor;
	assign report_direction = rq_rd.report_direction;
	assign error_code       = rq_rd.error_code;
	assign motor_state      = rq_rd.motor_state;
	assign upper_reached    = rq_rd.upper_reached;
	assign lower_reached    = rq_rd.lower_reached;
	assign drive_cmd        = rq_rd.drive_cmd;
	assign drive_timeout    = rq_rd.drive_timeout;

endmodule
